// ===== src/bis_pkg.sv =====
// Shared types and constants for the bilinear image scaler.
// No dependencies; compiled first.
`default_nettype none

package bis_pkg;

  localparam int PIX_W      = 8;
  localparam int SRC_W      = 9;
  localparam int DST_W      = 12;
  localparam int DIM_W      = 10;
  localparam int STEP_W     = 26;
  localparam int POS_FRAC   = 16;
  localparam int POS_W      = DST_W + STEP_W;
  localparam int IP_W       = POS_W - POS_FRAC;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH    = 3'd0,
    REG_SOURCE_HEIGHT   = 3'd1,
    REG_HORIZONTAL_STEP = 3'd2,
    REG_VERTICAL_STEP   = 3'd3,
    REG_INTERP_MODE     = 3'd4
  } reg_idx_t;

  localparam logic ACT_WRITE     = 1'b0;
  localparam logic ACT_QUERY     = 1'b1;
  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  // Live configuration, with frame dimensions held as the last valid index.
  typedef struct packed {
    logic [STEP_W-1:0] hstep;
    logic [STEP_W-1:0] vstep;
    logic              mode;
    logic [DIM_W-1:0]  last_col;
    logic [DIM_W-1:0]  last_row;
  } bis_cfg_t;

  // Classified item passed from the front end to the back end.
  typedef struct packed {
    logic             is_query;
    logic             wr_ok;
    logic [SRC_W-1:0] src_col;
    logic [SRC_W-1:0] src_row;
    logic [PIX_W-1:0] pixel;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [DST_W-1:0] dst_col;
    logic [DST_W-1:0] dst_row;
  } bis_item_t;

endpackage

`default_nettype wire

// ===== src/bis_if.sv =====
// Channel interfaces of the bilinear image scaler: input, result and config.
// Depends on bis_pkg.
`default_nettype none

interface bis_in_if;
  import bis_pkg::*;
  logic             valid;
  logic             ready;
  logic             action;
  logic [SRC_W-1:0] src_col;
  logic [SRC_W-1:0] src_row;
  logic [PIX_W-1:0] pixel_in;
  logic [DST_W-1:0] dst_col;
  logic [DST_W-1:0] dst_row;

  modport source (output valid, action, src_col, src_row, pixel_in, dst_col, dst_row,
                  input ready);
  modport sink   (input valid, action, src_col, src_row, pixel_in, dst_col, dst_row,
                  output ready);
endinterface

interface bis_out_if;
  import bis_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic [DST_W-1:0] out_col;
  logic [DST_W-1:0] out_row;

  modport source (output valid, pixel_out, out_col, out_row, input ready);
  modport sink   (input valid, pixel_out, out_col, out_row, output ready);
endinterface

interface bis_cfg_if;
  import bis_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/bis_front.sv =====
// Front end: accepts input transfers, checks write bounds and maps query
// coordinates to Q.16 source positions. Depends on bis_pkg and bis_if.
`default_nettype none

module bis_front #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  bis_in_if.sink              in_chan,
  input  bis_pkg::bis_cfg_t   cfg,
  output logic                q_push,
  output bis_pkg::bis_item_t  q_item,
  input  logic                q_full
);
  import bis_pkg::*;

  logic      f_valid_r;
  bis_item_t f_item_r;
  bis_item_t f_item_nxt;
  logic      accept;

  assign in_chan.ready = !f_valid_r || !q_full;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    f_item_nxt          = '0;
    f_item_nxt.is_query = (in_chan.action == ACT_QUERY);
    f_item_nxt.wr_ok    = (32'(in_chan.src_col) < MAX_WIDTH) &&
                          (32'(in_chan.src_row) < MAX_HEIGHT);
    f_item_nxt.src_col  = in_chan.src_col;
    f_item_nxt.src_row  = in_chan.src_row;
    f_item_nxt.pixel    = in_chan.pixel_in;
    f_item_nxt.pos_x    = POS_W'(in_chan.dst_col) * POS_W'(cfg.hstep);
    f_item_nxt.pos_y    = POS_W'(in_chan.dst_row) * POS_W'(cfg.vstep);
    f_item_nxt.dst_col  = in_chan.dst_col;
    f_item_nxt.dst_row  = in_chan.dst_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      f_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r <= f_item_nxt;
    end
  end

  assign q_push = f_valid_r && !q_full;
  assign q_item = f_item_r;

endmodule

`default_nettype wire

// ===== src/bis_queue.sv =====
// Short FIFO between the front and back ends of the scaler.
// Depends on bis_pkg.
`default_nettype none

module bis_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bis_pkg::bis_item_t  push_item,
  output logic                full,
  input  logic                pop,
  output bis_pkg::bis_item_t  head_item,
  output logic                empty
);
  import bis_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bis_item_t        slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign head_item = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue pushed while full");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
      push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count lost a push");

endmodule

`default_nettype wire

// ===== src/bis_back.sv =====
// Back end: neighbour location, four-bank frame store, horizontal and
// vertical interpolation, output register. Depends on bis_pkg and bis_if.
`default_nettype none

module bis_back #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int FRAC_BITS  = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bis_pkg::bis_cfg_t   cfg,
  input  bis_pkg::bis_item_t  q_item,
  input  logic                q_empty,
  output logic                q_pop,
  bis_out_if.source           out_chan
);
  import bis_pkg::*;

  localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
  localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int ACC_W      = PIX_W + FRAC_BITS + 1;
  localparam logic [FRAC_BITS:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [ACC_W-1:0]   HALF = ACC_W'(ONE) >> 1;

  // (1 - f) * a + f * b, rounded half up
  function automatic logic [PIX_W-1:0] lerp(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [FRAC_BITS-1:0] f);
    logic [ACC_W-1:0] acc;
    acc = ACC_W'(ONE - {1'b0, f}) * ACC_W'(a) + ACC_W'(f) * ACC_W'(b) + HALF;
    return acc[FRAC_BITS +: PIX_W];
  endfunction

  function automatic logic [PIX_W-1:0] pick(input logic [PIX_W-1:0] r0,
                                            input logic [PIX_W-1:0] r1,
                                            input logic [PIX_W-1:0] r2,
                                            input logic [PIX_W-1:0] r3,
                                            input logic py,
                                            input logic px);
    logic [PIX_W-1:0] v;
    case ({py, px})
      2'b00:   v = r0;
      2'b01:   v = r1;
      2'b10:   v = r2;
      default: v = r3;
    endcase
    return v;
  endfunction

  logic adv;

  // Locate neighbours and bank addresses
  logic [IP_W-1:0]      ip_x, ip_y;
  logic                 xclamp, yclamp;
  logic [DIM_W-1:0]     x0, x1, y0, y1;
  logic [DIM_W-1:0]     bcol [4];
  logic [DIM_W-1:0]     brow [4];
  logic [BANK_AW-1:0]   s1_addr_nxt [4];
  logic [3:0]           s1_wen_nxt;

  logic                 s1_valid_r, s1_query_r, s1_xclamp_r;
  logic [3:0]           s1_wen_r;
  logic [BANK_AW-1:0]   s1_addr_r [4];
  logic [PIX_W-1:0]     s1_wdata_r;
  logic                 s1_px0_r, s1_px1_r, s1_py0_r, s1_py1_r;
  logic [FRAC_BITS-1:0] s1_fx_r, s1_fy_r;
  logic [DST_W-1:0]     s1_col_r, s1_row_r;

  logic [PIX_W-1:0]     rdata_r [4];
  logic                 s2_valid_r;
  logic                 s2_px0_r, s2_px1_r, s2_py0_r, s2_py1_r;
  logic [FRAC_BITS-1:0] s2_fx_r, s2_fy_r;
  logic [DST_W-1:0]     s2_col_r, s2_row_r;

  logic [PIX_W-1:0]     p00, p01, p10, p11;
  logic                 s3_valid_r;
  logic [PIX_W-1:0]     s3_top_r, s3_bot_r, s3_near_r;
  logic [FRAC_BITS-1:0] s3_fy_r;
  logic [DST_W-1:0]     s3_col_r, s3_row_r;

  logic                 out_valid_r;
  logic [PIX_W-1:0]     out_pix_r;
  logic [DST_W-1:0]     out_col_r, out_row_r;

  // Whole back end holds while the output register is blocked
  assign adv   = !out_valid_r || out_chan.ready;
  assign q_pop = adv && !q_empty;

  always_comb begin
    ip_x   = q_item.pos_x[POS_W-1:POS_FRAC];
    ip_y   = q_item.pos_y[POS_W-1:POS_FRAC];
    xclamp = ip_x >= IP_W'(cfg.last_col);
    yclamp = ip_y >= IP_W'(cfg.last_row);
    x0     = xclamp ? cfg.last_col : ip_x[DIM_W-1:0];
    x1     = xclamp ? cfg.last_col : ip_x[DIM_W-1:0] + 1'b1;
    y0     = yclamp ? cfg.last_row : ip_y[DIM_W-1:0];
    y1     = yclamp ? cfg.last_row : ip_y[DIM_W-1:0] + 1'b1;
    for (int b = 0; b < 4; b++) begin
      if (q_item.is_query) begin
        bcol[b] = (x0[0] == b[0]) ? x0 : x1;
        brow[b] = (y0[0] == b[1]) ? y0 : y1;
      end else begin
        bcol[b] = DIM_W'(q_item.src_col);
        brow[b] = DIM_W'(q_item.src_row);
      end
      s1_addr_nxt[b] = BANK_AW'(brow[b][DIM_W-1:1]) * BANK_AW'(HALF_W) +
                       BANK_AW'(bcol[b][DIM_W-1:1]);
      s1_wen_nxt[b]  = !q_item.is_query && q_item.wr_ok &&
                       (q_item.src_col[0] == b[0]) && (q_item.src_row[0] == b[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= !q_empty;
      s2_valid_r  <= s1_valid_r && s1_query_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_query_r  <= q_item.is_query;
      s1_xclamp_r <= xclamp;
      s1_wen_r    <= s1_wen_nxt;
      s1_addr_r   <= s1_addr_nxt;
      s1_wdata_r  <= q_item.pixel;
      s1_px0_r    <= x0[0];
      s1_px1_r    <= x1[0];
      s1_py0_r    <= y0[0];
      s1_py1_r    <= y1[0];
      s1_fx_r     <= q_item.pos_x[POS_FRAC-1 -: FRAC_BITS];
      s1_fy_r     <= q_item.pos_y[POS_FRAC-1 -: FRAC_BITS];
      s1_col_r    <= q_item.dst_col;
      s1_row_r    <= q_item.dst_row;

      s2_px0_r    <= s1_px0_r;
      s2_px1_r    <= s1_px1_r;
      s2_py0_r    <= s1_py0_r;
      s2_py1_r    <= s1_py1_r;
      s2_fx_r     <= s1_fx_r;
      s2_fy_r     <= s1_fy_r;
      s2_col_r    <= s1_col_r;
      s2_row_r    <= s1_row_r;

      s3_top_r    <= lerp(p00, p01, s2_fx_r);
      s3_bot_r    <= lerp(p10, p11, s2_fx_r);
      s3_near_r   <= p00;
      s3_fy_r     <= s2_fy_r;
      s3_col_r    <= s2_col_r;
      s3_row_r    <= s2_row_r;

      out_pix_r   <= (cfg.mode == MODE_BILINEAR) ? lerp(s3_top_r, s3_bot_r, s3_fy_r)
                                                 : s3_near_r;
      out_col_r   <= s3_col_r;
      out_row_r   <= s3_row_r;
    end
  end

  // Frame store: bank index is {row parity, column parity}
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PIX_W-1:0] mem [BANK_DEPTH];
    always_ff @(posedge clk) begin
      if (adv && s1_valid_r) begin
        if (s1_wen_r[b]) begin
          mem[s1_addr_r[b]] <= s1_wdata_r;
        end else if (s1_query_r) begin
          rdata_r[b] <= mem[s1_addr_r[b]];
        end
      end
    end
  end

  assign p00 = pick(rdata_r[0], rdata_r[1], rdata_r[2], rdata_r[3], s2_py0_r, s2_px0_r);
  assign p01 = pick(rdata_r[0], rdata_r[1], rdata_r[2], rdata_r[3], s2_py0_r, s2_px1_r);
  assign p10 = pick(rdata_r[0], rdata_r[1], rdata_r[2], rdata_r[3], s2_py1_r, s2_px0_r);
  assign p11 = pick(rdata_r[0], rdata_r[1], rdata_r[2], rdata_r[3], s2_py1_r, s2_px1_r);

  assign out_chan.valid     = out_valid_r;
  assign out_chan.pixel_out = out_pix_r;
  assign out_chan.out_col   = out_col_r;
  assign out_chan.out_row   = out_row_r;

  a_single_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
      s1_valid_r |-> $onehot0(s1_wen_r))
    else $error("write reaches more than one bank");
  a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
      s1_valid_r && s1_query_r |-> s1_wen_r == 4'b0000)
    else $error("query item writes the frame store");
  a_neighbour_parity: assert property (@(posedge clk) disable iff (!rst_n)
      s1_valid_r && s1_query_r |-> ((s1_px0_r != s1_px1_r) != s1_xclamp_r))
    else $error("column neighbours not split across banks");
  a_out_follows_s3: assert property (@(posedge clk) disable iff (!rst_n)
      adv && s3_valid_r |=> out_valid_r)
    else $error("result dropped at output register");

endmodule

`default_nettype wire

// ===== src/bilinear_image_scaler_top.sv =====
// Bilinear / nearest-neighbour image scaler top level: config registers,
// front end, queue and back end. Depends on bis_pkg, bis_if and submodules.
//
// Usage:
//   in_chan   valid/ready input. action 0 stores pixel_in at (src_col, src_row);
//             action 1 queries destination pixel (dst_col, dst_row).
//   out_chan  valid/ready results, one per query: pixel_out plus echoed
//             out_col/out_row, in query order. Writes give no result.
//   cfg_chan  register writes by index (width, height, horizontal step,
//             vertical step, mode); always ready. Write only while idle.
// Throughput: one item per clock while out_chan does not stall. Each query
// reads all four neighbours in the same cycle from four banks split by row
// and column parity, so the frame store never limits the rate.
// Path: a query passes the front-end register, the queue, the bank address
// and bank read registers, the blend register and the result register.
// Reset: config returns to 512 x 512, unit steps, bilinear mode; pipeline and
// queue empty. The frame store is not cleared: pixels read before being
// written are undefined.
// Stall: if a result waits on a low out_chan.ready, the result register and
// back end hold; the queue fills, in_chan.ready falls only once it is full.
`default_nettype none

module bilinear_image_scaler_top #(
  parameter int MAX_WIDTH   = 512,
  parameter int MAX_HEIGHT  = 512,
  parameter int FRAC_BITS   = 8,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  bis_in_if.sink    in_chan,
  bis_out_if.source out_chan,
  bis_cfg_if.sink   cfg_chan
);
  import bis_pkg::*;

  // Effective dimension minus one: zero acts as one, oversize clamps.
  function automatic logic [DIM_W-1:0] last_index(input logic [DIM_W-1:0] v,
                                                  input int maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > maxv) begin
      r = DIM_W'(maxv - 1);
    end else begin
      r = v - 1'b1;
    end
    return r;
  endfunction

  logic [STEP_W-1:0] hstep_r, vstep_r;
  logic              mode_r;
  logic [DIM_W-1:0]  last_col_r, last_row_r;
  bis_cfg_t          cfg;

  logic      q_push, q_full, q_pop, q_empty;
  bis_item_t q_push_item, q_head_item;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hstep_r    <= STEP_W'(65536);
      vstep_r    <= STEP_W'(65536);
      mode_r     <= MODE_BILINEAR;
      last_col_r <= last_index(DIM_W'(512), MAX_WIDTH);
      last_row_r <= last_index(DIM_W'(512), MAX_HEIGHT);
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_chan.index)
        REG_SOURCE_WIDTH:    last_col_r <= last_index(cfg_chan.data[DIM_W-1:0], MAX_WIDTH);
        REG_SOURCE_HEIGHT:   last_row_r <= last_index(cfg_chan.data[DIM_W-1:0], MAX_HEIGHT);
        REG_HORIZONTAL_STEP: hstep_r    <= cfg_chan.data[STEP_W-1:0];
        REG_VERTICAL_STEP:   vstep_r    <= cfg_chan.data[STEP_W-1:0];
        REG_INTERP_MODE:     mode_r     <= cfg_chan.data[0];
        default: ;  // unknown index: drop
      endcase
    end
  end

  always_comb begin
    cfg.hstep    = hstep_r;
    cfg.vstep    = vstep_r;
    cfg.mode     = mode_r;
    cfg.last_col = last_col_r;
    cfg.last_row = last_row_r;
  end

  bis_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .cfg     (cfg),
    .q_push  (q_push),
    .q_item  (q_push_item),
    .q_full  (q_full)
  );

  bis_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .head_item (q_head_item),
    .empty     (q_empty)
  );

  bis_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_item   (q_head_item),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for bilinear_image_scaler_top: directed table, then random scenes.
// Predicts each query from a shadow frame store and shadow registers, unless the table pins it.
// Depends on bis_pkg, bis_if and the scaler RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bis_pkg::*;

  localparam int unsigned MAX_SIDE    = 512;
  localparam int unsigned FRAME_WORDS = MAX_SIDE * MAX_SIDE;
  localparam int unsigned FRAC_W      = 8;
  localparam int unsigned DST_MAX     = (1 << DST_W) - 1;
  localparam int unsigned IDLE_PCT    = 38;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned END_WAIT    = 16;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned ITEM_TARGET = 650;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(REG_INTERP_MODE + 1);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

  typedef struct packed {
    logic             action;
    logic [SRC_W-1:0] src_col;
    logic [SRC_W-1:0] src_row;
    logic [PIX_W-1:0] pixel;
    logic [DST_W-1:0] dst_col;
    logic [DST_W-1:0] dst_row;
  } scaler_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [DST_W-1:0] col;
    logic [DST_W-1:0] row;
  } scaled_pixel_t;

  typedef enum logic [1:0] {ROW_REG, ROW_PUT, ROW_ASK} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] word;
    logic [DST_W-1:0]      col;
    logic [DST_W-1:0]      row;
    logic [PIX_W-1:0]      pix;
    int                    want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  bis_in_if  in_chan ();
  bis_out_if out_chan ();
  bis_cfg_if cfg_chan ();

  bilinear_image_scaler_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always begin
    #4ns clk = 1'b1;
    #4ns clk = 1'b0;
  end

  // Shadow of the scaler: frame store, which entries hold data, and registers.
  logic [PIX_W-1:0]  shadow_frame [FRAME_WORDS];
  bit                frame_known  [FRAME_WORDS];
  logic [DIM_W-1:0]  set_cols  = DIM_W'(MAX_SIDE);
  logic [DIM_W-1:0]  set_rows  = DIM_W'(MAX_SIDE);
  logic [STEP_W-1:0] step_x    = STEP_W'(1 << POS_FRAC);
  logic [STEP_W-1:0] step_y    = STEP_W'(1 << POS_FRAC);
  logic              set_mode  = MODE_BILINEAR;

  scaled_pixel_t owed_pixels [$];
  int unsigned   items_sent   = 0;
  int unsigned   queries_sent = 0;
  int unsigned   answers_seen = 0;
  int unsigned   mismatches   = 0;
  int unsigned   quiet_cycles = 0;
  bit            calm         = 1'b0;

  task automatic flag(input string what);
    mismatches++;
    $display("[%0t] check failed: %s", $realtime, what);
  endtask

  function automatic int unsigned pix_addr(input int unsigned c, input int unsigned r);
    return r * MAX_SIDE + c;
  endfunction

  // Zero acts as one, anything past the store acts as the store size.
  function automatic int unsigned span(input logic [DIM_W-1:0] raw);
    if (raw == 0) return 1;
    return (32'(raw) > MAX_SIDE) ? MAX_SIDE : 32'(raw);
  endfunction

  function automatic void split_position(input logic [DST_W-1:0] d,
                                         input logic [STEP_W-1:0] step,
                                         input int unsigned dim,
                                         output int unsigned lo, output int unsigned hi,
                                         output logic [FRAC_W-1:0] frac);
    logic [POS_W-1:0] pos;
    logic [IP_W-1:0]  whole;
    pos   = POS_W'(d) * POS_W'(step);
    whole = pos[POS_W-1:POS_FRAC];
    frac  = pos[POS_FRAC-1 -: FRAC_W];
    // saturate at the last index: both neighbours become the edge pixel
    if (32'(whole) >= dim - 1) begin
      lo = dim - 1;
      hi = dim - 1;
    end else begin
      lo = 32'(whole);
      hi = 32'(whole) + 1;
    end
  endfunction

  // Weighted mix of two pixels, rounded half up.
  function automatic int unsigned blend(input int unsigned a, input int unsigned b,
                                        input logic [FRAC_W-1:0] f);
    int unsigned w;
    w = 32'(f);
    return (((1 << FRAC_W) - w) * a + w * b + (1 << (FRAC_W - 1))) >> FRAC_W;
  endfunction

  function automatic logic [PIX_W-1:0] scaled_pixel(input logic [DST_W-1:0] dc,
                                                    input logic [DST_W-1:0] dr);
    int unsigned       x0, x1, y0, y1, top, bot;
    int unsigned       p00, p01, p10, p11;
    logic [FRAC_W-1:0] fx, fy;
    split_position(dc, step_x, span(set_cols), x0, x1, fx);
    split_position(dr, step_y, span(set_rows), y0, y1, fy);
    p00 = 32'(shadow_frame[pix_addr(x0, y0)]);
    if (set_mode == MODE_NEAREST) return PIX_W'(p00);
    p01 = 32'(shadow_frame[pix_addr(x1, y0)]);
    p10 = 32'(shadow_frame[pix_addr(x0, y1)]);
    p11 = 32'(shadow_frame[pix_addr(x1, y1)]);
    top = blend(p00, p01, fx);
    bot = blend(p10, p11, fx);
    return PIX_W'(blend(top, bot, fy));
  endfunction

  // Hold the item until it is taken, then fold it into the shadow.
  task automatic transfer(input scaler_item_t it, input int pin);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.action   <= it.action;
    in_chan.src_col  <= it.src_col;
    in_chan.src_row  <= it.src_row;
    in_chan.pixel_in <= it.pixel;
    in_chan.dst_col  <= it.dst_col;
    in_chan.dst_row  <= it.dst_row;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
    calm = (items_sent >= 300) && (items_sent < 420);
    if (it.action == ACT_WRITE) begin
      shadow_frame[pix_addr(32'(it.src_col), 32'(it.src_row))] = it.pixel;
      frame_known[pix_addr(32'(it.src_col), 32'(it.src_row))]  = 1'b1;
    end else begin
      owed_pixels.push_back('{pix: (pin >= 0) ? PIX_W'(pin) : scaled_pixel(it.dst_col, it.dst_row),
                             col: it.dst_col, row: it.dst_row});
      queries_sent++;
    end
  endtask

  task automatic put_pixel(input int unsigned c, input int unsigned r,
                           input logic [PIX_W-1:0] v);
    scaler_item_t it;
    it.action  = ACT_WRITE;
    it.src_col = SRC_W'(c);
    it.src_row = SRC_W'(r);
    it.pixel   = v;
    it.dst_col = DST_W'($urandom);
    it.dst_row = DST_W'($urandom);
    transfer(it, -1);
  endtask

  // Fill any neighbour that has never been written, then send the query.
  task automatic ask_pixel(input logic [DST_W-1:0] dc, input logic [DST_W-1:0] dr,
                           input int pin);
    scaler_item_t      it;
    int unsigned       xs [2];
    int unsigned       ys [2];
    logic [FRAC_W-1:0] f;
    split_position(dc, step_x, span(set_cols), xs[0], xs[1], f);
    split_position(dr, step_y, span(set_rows), ys[0], ys[1], f);
    foreach (ys[i]) begin
      foreach (xs[j]) begin
        if (!frame_known[pix_addr(xs[j], ys[i])])
          put_pixel(xs[j], ys[i], PIX_W'($urandom_range(255)));
      end
    end
    it.action  = ACT_QUERY;
    it.src_col = SRC_W'($urandom);
    it.src_row = SRC_W'($urandom);
    it.pixel   = PIX_W'($urandom);
    it.dst_col = dc;
    it.dst_row = dr;
    transfer(it, pin);
  endtask

  // Leave cfg valid high between writes; the caller drops it after the last one.
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] word);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= word;
    do @(posedge clk); while (!cfg_chan.ready);
    case (idx)
      REG_SOURCE_WIDTH:    set_cols = word[DIM_W-1:0];
      REG_SOURCE_HEIGHT:   set_rows = word[DIM_W-1:0];
      REG_HORIZONTAL_STEP: step_x   = word[STEP_W-1:0];
      REG_VERTICAL_STEP:   step_y   = word[STEP_W-1:0];
      REG_INTERP_MODE:     set_mode = word[0];
      default: ;  // unknown index: dropped by the block
    endcase
  endtask

  task automatic drain(input int unsigned settle);
    in_chan.valid <= 1'b0;
    while (answers_seen < queries_sent) @(posedge clk);
    // writes give no result and may still be in the pipe
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] dim_word();
    logic [CFG_DATA_W-1:0] w;
    case ($urandom_range(9))
      0:       w = '0;
      1:       w = CFG_DATA_W'(MAX_SIDE);
      2:       w = CFG_DATA_W'($urandom_range((1 << DIM_W) - 1, 1));
      default: w = CFG_DATA_W'($urandom_range(8, 1));
    endcase
    // junk above the register width must be dropped
    if ($urandom_range(3) == 0) w[CFG_DATA_W-1:DIM_W] = (CFG_DATA_W - DIM_W)'($urandom);
    return w;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] step_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(32'h40000, 32'h2000));
    endcase
  endfunction

  function automatic logic [DST_W-1:0] pick_dst(input int unsigned dim,
                                                input logic [STEP_W-1:0] step);
    int unsigned reach;
    reach = (step == 0) ? DST_MAX : ((dim << POS_FRAC) / 32'(step)) + 1;
    if (reach > DST_MAX) reach = DST_MAX;
    case ($urandom_range(9))
      0, 1, 2:    return DST_W'($urandom_range(DST_MAX));
      3, 4, 5, 6: return DST_W'($urandom_range(reach));
      default:    return DST_W'($urandom_range(15));
    endcase
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] word);
    return '{kind: ROW_REG, idx: idx, word: word, col: '0, row: '0, pix: '0, want: -1};
  endfunction

  function automatic plan_row_t put_row(input int unsigned c, input int unsigned r,
                                        input logic [PIX_W-1:0] v);
    return '{kind: ROW_PUT, idx: '0, word: '0, col: DST_W'(c), row: DST_W'(r), pix: v,
             want: -1};
  endfunction

  function automatic plan_row_t ask_row(input int unsigned c, input int unsigned r,
                                        input int want);
    return '{kind: ROW_ASK, idx: '0, word: '0, col: DST_W'(c), row: DST_W'(r), pix: '0,
             want: want};
  endfunction

  always @(posedge clk) out_chan.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) begin : check_results
    scaled_pixel_t due;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      answers_seen++;
      if (owed_pixels.size() == 0) begin
        flag($sformatf("unexpected result at (%0d,%0d)", out_chan.out_col, out_chan.out_row));
      end else begin
        due = owed_pixels.pop_front();
        if (out_chan.pixel_out !== due.pix)
          flag($sformatf("pixel_out at (%0d,%0d): got %0d, want %0d",
                         due.col, due.row, out_chan.pixel_out, due.pix));
        if (out_chan.out_col !== due.col)
          flag($sformatf("out_col: got %0d, want %0d", out_chan.out_col, due.col));
        if (out_chan.out_row !== due.row)
          flag($sformatf("out_row: got %0d, want %0d", out_chan.out_row, due.row));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("bilinear_image_scaler_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    plan_row_t   plan [$];
    bit          cfg_open;
    bit          renew;
    int unsigned cw, ch, n_ops;
    rst_n            = 1'b0;
    in_chan.valid    = 1'b0;
    in_chan.action   = ACT_WRITE;
    in_chan.src_col  = '0;
    in_chan.src_row  = '0;
    in_chan.pixel_in = '0;
    in_chan.dst_col  = '0;
    in_chan.dst_row  = '0;
    cfg_chan.valid   = 1'b0;
    cfg_chan.index   = REG_SOURCE_WIDTH;
    cfg_chan.data    = '0;
    cfg_open         = 1'b0;

    // Reset settings first: 512 x 512, unit steps, bilinear.
    plan.push_back(put_row(0, 0, 200));
    plan.push_back(put_row(1, 0, 0));
    plan.push_back(put_row(0, 1, 255));
    plan.push_back(put_row(1, 1, 10));
    plan.push_back(ask_row(0, 0, 200));
    plan.push_back(reg_row(REG_HORIZONTAL_STEP, CFG_DATA_W'(1 << (POS_FRAC - 1))));
    plan.push_back(ask_row(1, 0, -1));
    plan.push_back(reg_row(REG_INTERP_MODE, CFG_DATA_W'(MODE_NEAREST)));
    plan.push_back(ask_row(1, 0, 200));
    // zero width acts as one column
    plan.push_back(reg_row(REG_SOURCE_WIDTH, '0));
    plan.push_back(ask_row(DST_MAX, 0, 200));
    plan.push_back(reg_row(REG_SOURCE_HEIGHT, '0));
    plan.push_back(reg_row(REG_INTERP_MODE, CFG_DATA_W'(MODE_BILINEAR)));
    plan.push_back(ask_row(DST_MAX, DST_MAX, 200));
    plan.push_back(put_row(MAX_SIDE - 1, 0, 1));
    plan.push_back(put_row(MAX_SIDE - 1, MAX_SIDE - 1, 77));
    // oversized width, largest step: saturate onto the last column
    plan.push_back(reg_row(REG_SOURCE_WIDTH, '1));
    plan.push_back(reg_row(REG_HORIZONTAL_STEP, '1));
    plan.push_back(reg_row(REG_VERTICAL_STEP, '0));
    plan.push_back(ask_row(DST_MAX, DST_MAX, 1));
    plan.push_back(reg_row(REG_SOURCE_HEIGHT, CFG_DATA_W'(MAX_SIDE)));
    plan.push_back(reg_row(REG_VERTICAL_STEP, '1));
    plan.push_back(reg_row(REG_SPARE_FIRST, '0));
    plan.push_back(ask_row(DST_MAX, DST_MAX, 77));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        if (!cfg_open) drain(SETTLE);
        set_reg(plan[i].idx, plan[i].word);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_chan.valid <= 1'b0;
        cfg_open = 1'b0;
        if (plan[i].kind == ROW_PUT)
          put_pixel(32'(plan[i].col), 32'(plan[i].row), plan[i].pix);
        else ask_pixel(plan[i].col, plan[i].row, plan[i].want);
      end
    end

    // Random scenes: new settings, load the frame if it is small, then scale with stray writes.
    while (items_sent < ITEM_TARGET) begin
      drain(SETTLE);
      set_reg(REG_SOURCE_WIDTH, dim_word());
      set_reg(REG_SOURCE_HEIGHT, dim_word());
      set_reg(REG_HORIZONTAL_STEP, step_word());
      set_reg(REG_VERTICAL_STEP, step_word());
      set_reg(REG_INTERP_MODE, CFG_DATA_W'($urandom));
      if ($urandom_range(3) == 0)
        set_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                CFG_DATA_W'($urandom));
      cfg_chan.valid <= 1'b0;
      cw = span(set_cols);
      ch = span(set_rows);
      if (cw * ch <= 64) begin
        renew = 1'($urandom_range(1));
        for (int unsigned r = 0; r < ch; r++) begin
          for (int unsigned c = 0; c < cw; c++) begin
            if (renew || !frame_known[pix_addr(c, r)])
              put_pixel(c, r, PIX_W'($urandom_range(255)));
          end
        end
      end
      n_ops = $urandom_range(60, 20);
      repeat (n_ops) begin
        if ($urandom_range(9) < 2) begin
          if ($urandom_range(1))
            put_pixel($urandom_range(MAX_SIDE - 1), $urandom_range(MAX_SIDE - 1),
                      PIX_W'($urandom_range(255)));
          else
            put_pixel($urandom_range(cw - 1), $urandom_range(ch - 1),
                      PIX_W'($urandom_range(255)));
        end else begin
          ask_pixel(pick_dst(cw, step_x), pick_dst(ch, step_y), -1);
        end
      end
    end

    drain(END_WAIT);
    if (owed_pixels.size() != 0)
      flag($sformatf("%0d expected results never came", owed_pixels.size()));
    if (mismatches == 0) begin
      $display("bilinear_image_scaler_top: match");
    end else begin
      $display("bilinear_image_scaler_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/bis_pkg.sv
src/bis_if.sv
src/bis_front.sv
src/bis_queue.sv
src/bis_back.sv
src/bilinear_image_scaler_top.sv
bench/testbench.sv
